### hw/rtl/blr_pkg.sv
`default_nettype none

package blr_pkg;

  // Grid and field sizes.
  localparam int GRID_SIZE = 64;
  localparam int COORD_W   = 6;
  localparam int COLOR_W   = 8;
  localparam int ADDR_W    = 12;
  localparam int SCREEN_W  = 7;
  localparam int ERR_W     = COORD_W + 2;

  // Configuration port.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = SCREEN_W;

  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = CFG_INDEX_W'(1);

  localparam logic [SCREEN_W-1:0] SCREEN_WIDTH_RESET  = SCREEN_W'(64);
  localparam logic [SCREEN_W-1:0] SCREEN_HEIGHT_RESET = SCREEN_W'(64);

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [ADDR_W-1:0]  pixel_address;
    logic               visible;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;
    logic               last_point;
  } pixel_t;

  // Limits a coordinate to the last grid column or row.
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
    logic [COORD_W:0] wide;
    wide = {1'b0, v};
    if (wide >= (COORD_W+1)'(GRID_SIZE)) begin
      return COORD_W'(GRID_SIZE - 1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bresenham_line_rasterizer.sv
`default_nettype none

// Channel    Direction  Handshake               Payload
// cmd        in         cmd_valid / cmd_ready   line_cmd_t: two endpoints and a color
// pix        out        pix_valid / pix_ready   pixel_t: one rasterized point
// cfg        in         cfg_we (no wait)        cfg_index, cfg_data: screen size
//
// A line with N points along its major axis passes through a setup state and then
// emits its N points, one point per cycle while the pix channel does not stall.
// The stepping loop runs through one error adder and sign test, used once
// per point. cmd_ready is high only while no line is in progress.
// A stalled pix channel holds the sequencer; no point is dropped.
// rst is synchronous and active high; it empties the block and sets the
// screen size to 64 by 64.
module bresenham_line_rasterizer
  import blr_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    cmd_valid,
  output logic                   cmd_ready,
  input  line_cmd_t              cmd,
  output logic                   pix_valid,
  input  wire                    pix_ready,
  output pixel_t                 pix,
  input  wire                    cfg_we,
  input  wire  [CFG_INDEX_W-1:0] cfg_index,
  input  wire  [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [1:0] {
    IDLE,
    SETUP,
    RUN
  } state_t;

  state_t state;

  // Screen size registers.
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;

  // Captured command.
  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [COLOR_W-1:0] red, green, blue;

  // Stepping state. major runs from its start to major_end; minor moves by
  // one toward its end whenever the error turns non-negative.
  logic               steep;
  logic [COORD_W-1:0] major;
  logic [COORD_W-1:0] major_end;
  logic [COORD_W-1:0] minor;
  logic               minor_up;
  logic [COORD_W-1:0] dmaj;
  logic [COORD_W-1:0] dmin;
  logic signed [ERR_W-1:0] err;

  // Setup values, worked out from the captured endpoints.
  logic [COORD_W-1:0] adx, ady;
  logic               steep_c;
  logic [COORD_W-1:0] p0_maj, p0_min, p1_maj, p1_min;
  logic [COORD_W-1:0] s_maj, s_min, e_maj, e_min;
  logic [COORD_W-1:0] dmaj_c;
  logic [COORD_W:0]   half_c;

  always_comb begin
    adx     = (ax > bx) ? ax - bx : bx - ax;
    ady     = (ay > by) ? ay - by : by - ay;
    steep_c = ady > adx;
    p0_maj  = steep_c ? ay : ax;
    p0_min  = steep_c ? ax : ay;
    p1_maj  = steep_c ? by : bx;
    p1_min  = steep_c ? bx : by;
    if (p0_maj > p1_maj) begin
      s_maj = p1_maj;
      s_min = p1_min;
      e_maj = p0_maj;
      e_min = p0_min;
    end else begin
      s_maj = p0_maj;
      s_min = p0_min;
      e_maj = p1_maj;
      e_min = p1_min;
    end
    dmaj_c = e_maj - s_maj;
    half_c = ({1'b0, dmaj_c} + (COORD_W+1)'(2)) >> 1;
  end

  // The shared step unit: one error add, a sign test and the correction.
  logic signed [ERR_W-1:0] err_sum;
  logic signed [ERR_W-1:0] err_next;
  logic                    take_minor;
  logic [COORD_W-1:0]      minor_next;

  always_comb begin
    err_sum    = err + $signed({2'b00, dmin});
    take_minor = !err_sum[ERR_W-1];
    err_next   = take_minor ? err_sum - $signed({2'b00, dmaj}) : err_sum;
    if (!take_minor) begin
      minor_next = minor;
    end else if (minor_up) begin
      minor_next = minor + COORD_W'(1);
    end else begin
      minor_next = minor - COORD_W'(1);
    end
  end

  // Point being emitted this cycle.
  logic [COORD_W-1:0]  px, py;
  logic [2*COORD_W:0]  addr_full;
  logic                emit;
  logic                at_end;

  always_comb begin
    px        = steep ? minor : major;
    py        = steep ? major : minor;
    addr_full = ({{(COORD_W+1){1'b0}}, py} * {{COORD_W{1'b0}}, screen_width}) +
                {{(COORD_W+1){1'b0}}, px};
    emit      = (state == RUN) && (!pix_valid || pix_ready);
    at_end    = major == major_end;
  end

  assign cmd_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      pix_valid     <= 1'b0;
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height <= cfg_data;
          default: ;
        endcase
      end

      // A point taken while a new one is emitted keeps the output valid.
      if (pix_valid && pix_ready && !emit) begin
        pix_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (cmd_valid) begin
            ax    <= clamp_coord(cmd.start_x);
            ay    <= clamp_coord(cmd.start_y);
            bx    <= clamp_coord(cmd.end_x);
            by    <= clamp_coord(cmd.end_y);
            red   <= cmd.red;
            green <= cmd.green;
            blue  <= cmd.blue;
            state <= SETUP;
          end
        end
        SETUP: begin
          steep     <= steep_c;
          major     <= s_maj;
          major_end <= e_maj;
          minor     <= s_min;
          minor_up  <= s_min < e_min;
          dmaj      <= dmaj_c;
          dmin      <= (s_min > e_min) ? s_min - e_min : e_min - s_min;
          err       <= ERR_W'(0) - $signed({1'b0, half_c});
          state     <= RUN;
        end
        RUN: begin
          if (emit) begin
            pix_valid         <= 1'b1;
            pix.pixel_x       <= px;
            pix.pixel_y       <= py;
            pix.pixel_address <= addr_full[ADDR_W-1:0];
            pix.visible       <= ({1'b0, px} < screen_width) &&
                                 ({1'b0, py} < screen_height);
            pix.out_red       <= red;
            pix.out_green     <= green;
            pix.out_blue      <= blue;
            pix.last_point    <= at_end;
            err               <= err_next;
            minor             <= minor_next;
            major             <= major + COORD_W'(1);
            if (at_end) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The error stays negative between steps.
  a_err_negative: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> err[ERR_W-1])
    else $error("error term not negative while stepping");

  // The minor delta never exceeds the major delta.
  a_minor_le_major: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (dmin <= dmaj))
    else $error("minor delta exceeds major delta");

  // The major coordinate never passes the line's end.
  a_major_bound: assert property (@(posedge clk) disable iff (rst)
    (state == RUN) |-> (major <= major_end))
    else $error("major coordinate past end of line");

  // Emitting the final point returns the sequencer to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit && at_end) |=> (state == IDLE && pix_valid && pix.last_point))
    else $error("final point did not end the line");
`endif

endmodule

`default_nettype wire

### test/tb_bresenham_line_rasterizer.sv
`timescale 1ns / 100ps

module tb_bresenham_line_rasterizer;
  import blr_pkg::*;

  // The first register index that maps to nothing; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNMAPPED = REG_SCREEN_HEIGHT + 1'b1;
  localparam int LAST_COORD = GRID_SIZE - 1;
  // A broken block can mismatch on every point, so only the first reports are printed.
  localparam int REPORT_LIMIT = 100;
  localparam int PHASE_COUNT = 6;
  localparam int LINES_PER_PHASE = 53;

  // Keeps the pixels that the accepted lines must produce, in output order,
  // and a private copy of the screen size registers.
  class pixel_scoreboard;
    pixel_t expected_pixels[$];
    logic [SCREEN_W-1:0] width;
    logic [SCREEN_W-1:0] height;
    int errors;

    function new();
      width = SCREEN_WIDTH_RESET;
      height = SCREEN_HEIGHT_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == REG_SCREEN_WIDTH) begin
        width = data;
      end else if (index == REG_SCREEN_HEIGHT) begin
        height = data;
      end
    endfunction

    function int span(int a, int b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Walks the line the same way the block does and queues one pixel per step.
    // Endpoints are 6 bits wide, so they never exceed the grid and need no clamp.
    function void note_line(line_cmd_t c);
      int ax, ay, bx, by, t, dmaj, dmin, err, minor, mstep, major, px, py;
      bit steep;
      pixel_t p;
      ax = c.start_x;
      ay = c.start_y;
      bx = c.end_x;
      by = c.end_y;
      steep = span(ay, by) > span(ax, bx);
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      dmaj = bx - ax;
      dmin = span(ay, by);
      err = -((dmaj + 2) / 2);
      minor = ay;
      mstep = (ay < by) ? 1 : -1;
      for (major = ax; major <= bx; major++) begin
        px = steep ? minor : major;
        py = steep ? major : minor;
        p.pixel_x = COORD_W'(px);
        p.pixel_y = COORD_W'(py);
        p.pixel_address = ADDR_W'(py * int'(width) + px);
        p.visible = (px < int'(width)) && (py < int'(height));
        p.out_red = c.red;
        p.out_green = c.green;
        p.out_blue = c.blue;
        p.last_point = (major == bx);
        expected_pixels.push_back(p);
        err += dmin;
        if (err >= 0) begin
          minor += mstep;
          err -= dmaj;
        end
      end
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $error("%s: expected %0d, got %0d", name, want, got);
        end
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) begin
          $error("pixel (%0d,%0d) arrived with none expected", got.pixel_x, got.pixel_y);
        end
        return;
      end
      want = expected_pixels.pop_front();
      compare("pixel_x", want.pixel_x, got.pixel_x);
      compare("pixel_y", want.pixel_y, got.pixel_y);
      compare("pixel_address", want.pixel_address, got.pixel_address);
      compare("visible", want.visible, got.visible);
      compare("out_red", want.out_red, got.out_red);
      compare("out_green", want.out_green, got.out_green);
      compare("out_blue", want.out_blue, got.out_blue);
      compare("last_point", want.last_point, got.last_point);
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  line_cmd_t cmd = '0;
  logic pix_valid;
  logic pix_ready = 1'b0;
  pixel_t pix;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Chance, in percent, that a side holds off for a cycle.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  pixel_scoreboard sb = new();

  bresenham_line_rasterizer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // The receiver decides at each falling edge whether it takes a pixel in the
  // coming cycle, and every pixel accepted at a rising edge is checked.
  always @(negedge clk) begin
    pix_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && pix_valid && pix_ready) begin
      sb.check_pixel(pix);
    end
  end

  // Saturates a computed coordinate onto the grid.
  function automatic logic [COORD_W-1:0] to_coord(int v);
    if (v < 0) begin
      return '0;
    end
    if (v > LAST_COORD) begin
      return COORD_W'(LAST_COORD);
    end
    return COORD_W'(v);
  endfunction

  function automatic line_cmd_t line_of(int x0, int y0, int x1, int y1, int r, int g, int b);
    line_cmd_t c;
    c.start_x = to_coord(x0);
    c.start_y = to_coord(y0);
    c.end_x = to_coord(x1);
    c.end_y = to_coord(y1);
    c.red = COLOR_W'(r);
    c.green = COLOR_W'(g);
    c.blue = COLOR_W'(b);
    return c;
  endfunction

  // About a third of the lines are short so that the run stays quick; the rest
  // are fully random, axis aligned, diagonal, single points or edge to edge.
  function automatic line_cmd_t random_line();
    line_cmd_t c;
    int kind, len;
    c.start_x = COORD_W'($urandom);
    c.start_y = COORD_W'($urandom);
    c.end_x = COORD_W'($urandom);
    c.end_y = COORD_W'($urandom);
    c.red = COLOR_W'($urandom);
    c.green = COLOR_W'($urandom);
    c.blue = COLOR_W'($urandom);
    kind = $urandom_range(99);
    if (kind < 40) begin
      // Endpoints stay fully random.
    end else if (kind < 75) begin
      c.end_x = to_coord(int'(c.start_x) + int'($urandom_range(8)) - 4);
      c.end_y = to_coord(int'(c.start_y) + int'($urandom_range(8)) - 4);
    end else if (kind < 85) begin
      len = $urandom_range(LAST_COORD);
      case ($urandom_range(2))
        0: c.end_y = c.start_y;
        1: c.end_x = c.start_x;
        default: begin
          c.end_x = to_coord(int'(c.start_x) + ($urandom_range(1) ? len : -len));
          c.end_y = to_coord(int'(c.start_y) + ($urandom_range(1) ? len : -len));
        end
      endcase
    end else if (kind < 92) begin
      c.end_x = c.start_x;
      c.end_y = c.start_y;
    end else begin
      c.start_x = $urandom_range(1) ? COORD_W'(LAST_COORD) : '0;
      c.end_x = (c.start_x == 0) ? COORD_W'(LAST_COORD) : '0;
      c.start_y = $urandom_range(1) ? COORD_W'(LAST_COORD) : '0;
      c.end_y = COORD_W'($urandom);
    end
    return c;
  endfunction

  // Presents one line at a falling edge, after an optional random gap, and
  // holds it until the block takes it. Returns at the falling edge after the
  // handshake so the next line, or a lowered valid, follows without a race.
  task automatic send_line(line_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid = 1'b0;
      @(negedge clk);
    end
    cmd_valid = 1'b1;
    cmd = c;
    do begin
      @(posedge clk);
    end while (!cmd_ready);
    sb.note_line(c);
    @(negedge clk);
  endtask

  // The write takes effect at the rising edge while cfg_we is held high.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    sb.set_reg(index, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every queued pixel has come out. Each line ends on a pixel,
  // so the block is idle then.
  task automatic drain();
    while (sb.expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // Screen sizes for the random phases: the smallest, zero sizes that blank
  // everything, the largest (the address wraps), the reset size, a width
  // just above the grid, and finally a random setting.
  int phase_width[PHASE_COUNT] = '{1, 0, 127, 64, 65, 0};
  int phase_height[PHASE_COUNT] = '{1, 127, 0, 64, 2, 0};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed lines run at the reset screen size, which checks the reset
    // values of both registers.
    send_idle_pct = 14;
    recv_idle_pct = 76;
    send_line(line_of(0, 0, 0, 0, 0, 0, 0));
    send_line(line_of(63, 63, 63, 63, 255, 255, 255));
    send_line(line_of(0, 0, 63, 0, 170, 85, 170));
    send_line(line_of(63, 63, 63, 0, 85, 170, 85));
    send_line(line_of(0, 0, 63, 63, 1, 128, 254));
    send_line(line_of(63, 0, 0, 63, 254, 127, 1));
    send_line(line_of(0, 0, 63, 10, 15, 240, 60));
    send_line(line_of(63, 5, 0, 20, 240, 15, 195));
    send_line(line_of(5, 0, 12, 63, 0, 255, 0));
    send_line(line_of(40, 63, 30, 0, 255, 0, 255));
    send_line(line_of(0, 0, 2, 1, 1, 2, 4));
    send_line(line_of(10, 10, 11, 12, 8, 16, 32));
    send_line(line_of(20, 20, 19, 21, 64, 128, 255));
    send_line(line_of(0, 63, 1, 62, 200, 100, 50));
    send_line(line_of(62, 1, 63, 63, 7, 77, 177));
    // Lines longer in one axis by exactly one step.
    send_line(line_of(30, 30, 34, 33, 90, 91, 92));
    send_line(line_of(33, 34, 30, 30, 93, 94, 95));
    cmd_valid = 1'b0;

    // Random phases: the first two stall mostly the receiver, the next two
    // mostly the sender, and the last two run at full rate.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 76;
        recv_idle_pct = 14;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      if (phase == PHASE_COUNT - 1) begin
        phase_width[phase] = $urandom_range(127);
        phase_height[phase] = $urandom_range(127);
      end
      // A write to an unmapped index must leave the screen size alone.
      write_reg(CFG_INDEX_W'($urandom_range(2 ** CFG_INDEX_W - 1, REG_FIRST_UNMAPPED)),
                CFG_DATA_W'($urandom));
      write_reg(REG_SCREEN_WIDTH, CFG_DATA_W'(phase_width[phase]));
      write_reg(REG_SCREEN_HEIGHT, CFG_DATA_W'(phase_height[phase]));
      repeat (LINES_PER_PHASE) send_line(random_line());
      cmd_valid = 1'b0;
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this, even with every line at
  // full length and the receiver stalling most of the time.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
